// ----- rtl/sisp_pkg.sv -----
package sisp_pkg;

    localparam logic [31:0] SP_MAGIC        = 32'hED26_FF3A;
    localparam logic [15:0] SP_RAW          = 16'hCAC1;
    localparam logic [15:0] SP_FILL         = 16'hCAC2;
    localparam logic [15:0] SP_DONTCARE     = 16'hCAC3;
    localparam logic [15:0] SP_CRC          = 16'hCAC4;
    localparam logic [15:0] SP_HDR_LEN      = 16'd28;
    localparam logic [15:0] SP_CHK_LEN      = 16'd12;
    localparam logic [15:0] MAX_HEADER_LEN  = 16'd4096;
    localparam logic [31:0] MAX_CHUNKS      = 32'd1048576;
    localparam logic [62:0] SP_DEFAULT_MAX  = 63'(64) << 30;

    localparam int CNT_W   = 13;
    localparam int CHUNK_W = 21;
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);

    typedef enum logic [2:0] {
        PH_HDR,
        PH_HDR_EXT,
        PH_CHK,
        PH_RAW,
        PH_WORD,
        PH_DONE
    } t_phase;

    typedef enum logic [2:0] {
        EV_RAW    = 3'd0,
        EV_HEADER = 3'd1,
        EV_CHUNK  = 3'd2,
        EV_DONE   = 3'd3,
        EV_ERROR  = 3'd4
    } t_event;

    typedef enum logic [3:0] {
        ERR_NONE        = 4'd0,
        ERR_MAGIC       = 4'd1,
        ERR_VERSION     = 4'd2,
        ERR_HDR_SIZES   = 4'd3,
        ERR_BLOCK_SIZE  = 4'd4,
        ERR_CHUNK_COUNT = 4'd5,
        ERR_TOO_LARGE   = 4'd6,
        ERR_CHUNK_SIZE  = 4'd7,
        ERR_RAW_SIZE    = 4'd8,
        ERR_PAYLOAD     = 4'd9,
        ERR_DC_PAYLOAD  = 4'd10,
        ERR_CRC_BLOCKS  = 4'd11,
        ERR_TYPE        = 4'd12,
        ERR_BLK_EXCEED  = 4'd13,
        ERR_BLK_SHORT   = 4'd14,
        ERR_TRUNCATED   = 4'd15
    } t_err;

    typedef struct packed {
        t_event      event_res;
        logic [1:0]  chunk_kind;
        logic [31:0] block_count;
        logic [31:0] word_value;
        logic [31:0] block_bytes;
        logic [7:0]  payload_byte;
        t_err        error_code;
        logic        last_of_run;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_push;

endpackage

// ----- rtl/sisp_if.sv -----
interface sisp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_input;

    modport source (output valid, output data_byte, output end_of_input, input ready);
    modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface sisp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [1:0]  chunk_kind;
    logic [31:0] block_count;
    logic [31:0] word_value;
    logic [31:0] block_bytes;
    logic [7:0]  payload_byte;
    logic [3:0]  error_code;
    logic        last_of_run;

    modport source (output valid, output event_res, output chunk_kind, output block_count,
                    output word_value, output block_bytes, output payload_byte,
                    output error_code, output last_of_run, input ready);
    modport sink   (input valid, input event_res, input chunk_kind, input block_count,
                    input word_value, input block_bytes, input payload_byte,
                    input error_code, input last_of_run, output ready);
endinterface

// ----- rtl/sisp_core.sv -----
module sisp_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [62:0]      i_cfg_wdata,
    input  logic             i_take,
    input  logic [7:0]       i_byte,
    input  logic             i_eoi,
    output sisp_pkg::t_push  o_push
);
    import sisp_pkg::*;

    t_phase              r_phase, n_phase;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [15:0]         r_hlen, n_hlen;
    logic [15:0]         r_chlen, n_chlen;
    logic [31:0]         r_bsize, n_bsize;
    logic [31:0]         r_tblocks, n_tblocks;
    logic [CHUNK_W-1:0]  r_tchunks, n_tchunks;
    logic [CHUNK_W-1:0]  r_cdone, n_cdone;
    logic [32:0]         r_bseen, n_bseen;
    logic [15:0]         r_ctype, n_ctype;
    logic [31:0]         r_cblocks, n_cblocks;
    logic [31:0]         r_pleft, n_pleft;
    logic [31:0]         r_word, n_word;
    logic                r_failed, n_failed;
    logic [62:0]         r_max;
    logic [63:0]         r_prod;

    logic                m_v, e_v, t_v;
    t_result             m_res, e_res, t_res;
    logic [31:0]         w;
    logic [31:0]         payload;
    logic                go_end, go_chk, hend, fin;
    logic [1:0]          kind;

    // product of block size with total or chunk blocks, settles before use
    always_ff @(posedge i_clk) begin
        r_prod <= 64'(((r_phase == PH_HDR) ? r_tblocks : r_cblocks)) * 64'(r_bsize);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= SP_DEFAULT_MAX;
        end else if (i_cfg_we) begin
            r_max <= i_cfg_wdata;
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_cnt     = r_cnt;
        n_hlen    = r_hlen;
        n_chlen   = r_chlen;
        n_bsize   = r_bsize;
        n_tblocks = r_tblocks;
        n_tchunks = r_tchunks;
        n_cdone   = r_cdone;
        n_bseen   = r_bseen;
        n_ctype   = r_ctype;
        n_cblocks = r_cblocks;
        n_pleft   = r_pleft;
        n_word    = r_word;
        n_failed  = r_failed;
        m_v = 1'b0;
        e_v = 1'b0;
        t_v = 1'b0;
        m_res = '0;
        e_res = '0;
        t_res = '0;
        hend = 1'b0;
        fin = 1'b0;
        go_end = 1'b0;
        go_chk = 1'b0;
        w = {i_byte, r_word[31:8]};
        payload = w - 32'(r_chlen);
        kind = r_ctype[1:0] - 2'b01;

        if (i_take && !r_failed && r_phase != PH_DONE) begin
            n_word = w;
            n_cnt = r_cnt + 1'b1;
            unique case (r_phase)
                PH_HDR: begin
                    if (r_cnt == CNT_W'(3)) begin
                        if (w != SP_MAGIC) begin
                            m_v = 1'b1; m_res.error_code = ERR_MAGIC;
                        end
                    end else if (r_cnt == CNT_W'(5)) begin
                        if (w[31:16] != 16'd1) begin
                            m_v = 1'b1; m_res.error_code = ERR_VERSION;
                        end
                    end else if (r_cnt == CNT_W'(9)) begin
                        n_hlen = w[31:16];
                    end else if (r_cnt == CNT_W'(11)) begin
                        n_chlen = w[31:16];
                        if (r_hlen < SP_HDR_LEN || r_hlen > MAX_HEADER_LEN ||
                            w[31:16] < SP_CHK_LEN || w[31:16] > MAX_HEADER_LEN) begin
                            m_v = 1'b1; m_res.error_code = ERR_HDR_SIZES;
                        end
                    end else if (r_cnt == CNT_W'(15)) begin
                        n_bsize = w;
                        if (w == 32'd0 || w[1:0] != 2'd0) begin
                            m_v = 1'b1; m_res.error_code = ERR_BLOCK_SIZE;
                        end
                    end else if (r_cnt == CNT_W'(19)) begin
                        n_tblocks = w;
                    end else if (r_cnt == CNT_W'(23)) begin
                        if (w > MAX_CHUNKS) begin
                            m_v = 1'b1; m_res.error_code = ERR_CHUNK_COUNT;
                        end else begin
                            n_tchunks = w[CHUNK_W-1:0];
                            if (r_prod > {1'b0, r_max}) begin
                                m_v = 1'b1; m_res.error_code = ERR_TOO_LARGE;
                            end
                        end
                    end else if (r_cnt == CNT_W'(27)) begin
                        m_v = 1'b1;
                        m_res.event_res = EV_HEADER;
                        m_res.block_count = r_tblocks;
                        m_res.word_value = w;
                        m_res.block_bytes = r_bsize;
                        if (r_hlen <= SP_HDR_LEN) begin
                            hend = 1'b1;
                        end else begin
                            n_phase = PH_HDR_EXT;
                        end
                    end
                    if (m_v && m_res.error_code != ERR_NONE) begin
                        m_res.event_res = EV_ERROR;
                        n_failed = 1'b1;
                    end
                end
                PH_HDR_EXT: begin
                    if (17'(r_cnt) + 17'd1 >= 17'(r_hlen)) begin
                        hend = 1'b1;
                    end
                end
                PH_CHK: begin
                    if (r_cnt == CNT_W'(1)) begin
                        n_ctype = w[31:16];
                    end else if (r_cnt == CNT_W'(7)) begin
                        n_cblocks = w;
                    end else if (r_cnt == CNT_W'(11)) begin
                        if (w < 32'(r_chlen)) begin
                            m_v = 1'b1; m_res.error_code = ERR_CHUNK_SIZE;
                        end else begin
                            n_pleft = payload;
                            if (r_ctype == SP_RAW) begin
                                if ({32'd0, payload} != r_prod) begin
                                    m_v = 1'b1; m_res.error_code = ERR_RAW_SIZE;
                                end
                            end else if (r_ctype == SP_FILL) begin
                                if (payload != 32'd4) begin
                                    m_v = 1'b1; m_res.error_code = ERR_PAYLOAD;
                                end
                            end else if (r_ctype == SP_DONTCARE) begin
                                if (payload != 32'd0) begin
                                    m_v = 1'b1; m_res.error_code = ERR_DC_PAYLOAD;
                                end
                            end else if (r_ctype == SP_CRC) begin
                                if (payload != 32'd4) begin
                                    m_v = 1'b1; m_res.error_code = ERR_PAYLOAD;
                                end else if (r_cblocks != 32'd0) begin
                                    m_v = 1'b1; m_res.error_code = ERR_CRC_BLOCKS;
                                end
                            end else begin
                                m_v = 1'b1; m_res.error_code = ERR_TYPE;
                            end
                            if (!m_v) begin
                                n_bseen = r_bseen + 33'(r_cblocks);
                                if (n_bseen > {1'b0, r_tblocks}) begin
                                    m_v = 1'b1; m_res.error_code = ERR_BLK_EXCEED;
                                end
                            end
                        end
                        if (m_v) begin
                            m_res.event_res = EV_ERROR;
                            n_failed = 1'b1;
                        end
                    end
                    if (!n_failed && r_cnt >= CNT_W'(11) &&
                        17'(r_cnt) + 17'd1 >= 17'(r_chlen)) begin
                        if (r_ctype == SP_FILL || r_ctype == SP_CRC) begin
                            n_phase = PH_WORD;
                            n_cnt = '0;
                        end else begin
                            m_v = 1'b1;
                            m_res.event_res = EV_CHUNK;
                            m_res.chunk_kind = kind;
                            m_res.block_count = r_cblocks;
                            if (r_ctype == SP_RAW && n_pleft != 32'd0) begin
                                n_phase = PH_RAW;
                                n_cnt = '0;
                            end else begin
                                fin = 1'b1;
                            end
                        end
                    end
                end
                PH_RAW: begin
                    m_v = 1'b1;
                    m_res.event_res = EV_RAW;
                    m_res.payload_byte = i_byte;
                    n_pleft = r_pleft - 32'd1;
                    fin = (n_pleft == 32'd0);
                end
                PH_WORD: begin
                    n_pleft = r_pleft - 32'd1;
                    if (n_pleft == 32'd0) begin
                        m_v = 1'b1;
                        m_res.event_res = EV_CHUNK;
                        m_res.chunk_kind = kind;
                        m_res.block_count = r_cblocks;
                        m_res.word_value = w;
                        fin = 1'b1;
                    end
                end
                default: begin
                end
            endcase

            if (hend) begin
                if (r_tchunks == '0) begin
                    go_end = 1'b1;
                end else begin
                    go_chk = 1'b1;
                end
            end
            if (fin) begin
                n_cdone = r_cdone + 1'b1;
                if (n_cdone == r_tchunks) begin
                    go_end = 1'b1;
                end else begin
                    go_chk = 1'b1;
                end
            end
            if (go_chk) begin
                n_phase = PH_CHK;
                n_cnt = '0;
            end
            if (go_end) begin
                e_v = 1'b1;
                if (n_bseen != {1'b0, r_tblocks}) begin
                    e_res.event_res = EV_ERROR;
                    e_res.error_code = ERR_BLK_SHORT;
                    n_failed = 1'b1;
                end else begin
                    e_res.event_res = EV_DONE;
                end
                n_phase = PH_DONE;
            end
        end

        if (i_take && i_eoi) begin
            if (!n_failed && n_phase != PH_DONE) begin
                t_v = 1'b1;
                t_res.event_res = EV_ERROR;
                t_res.error_code = ERR_TRUNCATED;
            end
            n_phase   = PH_HDR;
            n_cnt     = '0;
            n_hlen    = '0;
            n_chlen   = '0;
            n_bsize   = '0;
            n_tblocks = '0;
            n_tchunks = '0;
            n_cdone   = '0;
            n_bseen   = '0;
            n_ctype   = '0;
            n_cblocks = '0;
            n_pleft   = '0;
            n_word    = '0;
            n_failed  = 1'b0;
        end
    end

    // pack up to two results in order, last one flagged
    always_comb begin
        o_push = '0;
        o_push.count = 2'(m_v) + 2'(e_v) + 2'(t_v);
        o_push.res0 = m_v ? m_res : (e_v ? e_res : t_res);
        o_push.res1 = (m_v && e_v) ? e_res : t_res;
        o_push.res0.last_of_run = (o_push.count == 2'd1);
        o_push.res1.last_of_run = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HDR;
            r_cnt     <= '0;
            r_hlen    <= '0;
            r_chlen   <= '0;
            r_bsize   <= '0;
            r_tblocks <= '0;
            r_tchunks <= '0;
            r_cdone   <= '0;
            r_bseen   <= '0;
            r_ctype   <= '0;
            r_cblocks <= '0;
            r_pleft   <= '0;
            r_word    <= '0;
            r_failed  <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_cnt     <= n_cnt;
            r_hlen    <= n_hlen;
            r_chlen   <= n_chlen;
            r_bsize   <= n_bsize;
            r_tblocks <= n_tblocks;
            r_tchunks <= n_tchunks;
            r_cdone   <= n_cdone;
            r_bseen   <= n_bseen;
            r_ctype   <= n_ctype;
            r_cblocks <= n_cblocks;
            r_pleft   <= n_pleft;
            r_word    <= n_word;
            r_failed  <= n_failed;
        end
    end

    a_quiet_after_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && r_failed && !i_eoi) |-> (o_push.count == 2'd0))
        else $error("result produced after error");

    a_quiet_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && r_phase == PH_DONE && !i_eoi) |-> (o_push.count == 2'd0))
        else $error("result produced after completion");

    a_eoi_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && i_eoi) |=> (r_phase == PH_HDR && !r_failed && r_cnt == '0))
        else $error("end of input did not return to header phase");

endmodule

// ----- rtl/sisp_outq.sv -----
module sisp_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sisp_pkg::t_push   i_push,
    input  logic              i_pop,
    output logic              o_room,
    output logic              o_valid,
    output sisp_pkg::t_result o_res
);
    import sisp_pkg::*;

    t_result           r_mem [OQ_DEPTH];
    logic [OQ_AW-1:0]  r_wp, r_rp;
    logic [OQ_AW:0]    r_cnt;

    assign o_room  = (r_cnt <= (OQ_AW+1)'(OQ_DEPTH - 2));
    assign o_valid = (r_cnt != '0);
    assign o_res   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wp] <= i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wp + 1'b1] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + OQ_AW'(i_push.count);
            r_rp  <= r_rp + OQ_AW'(i_pop);
            r_cnt <= r_cnt + (OQ_AW+1)'(i_push.count) - (OQ_AW+1)'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count != 2'd0) |-> (r_cnt + (OQ_AW+1)'(i_push.count)
                                    <= (OQ_AW+1)'(OQ_DEPTH)))
        else $error("result queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty result queue");

    a_cnt_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (OQ_AW+1)'(OQ_DEPTH))
        else $error("result queue count out of range");

endmodule

// ----- rtl/sparse_image_stream_parser.sv -----
// channel   dir  transfer when         payload
// i_in      in   valid && ready        data_byte, end_of_input
// o_out     out  valid && ready        event_res .. last_of_run
// cfg       in   i_cfg_we              max_expanded_bytes (63 bits)
//
// one input byte per cycle; each byte is handled in the cycle it is taken by the
// parse logic and its results (up to two) land in a four-entry output queue
// input is taken while the queue has room for two results, so a byte that
// makes two results needs two output transfers to drain
// synchronous active-low reset clears all parse state, the limit goes to 64 GiB
// output stalls only hold the queue; the parser keeps going until it fills
module sparse_image_stream_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [62:0]       i_cfg_wdata,
    sisp_in_if.sink           i_in,
    sisp_out_if.source        o_out
);
    import sisp_pkg::*;

    t_push   push;
    t_result res;
    logic    room;
    logic    take;
    logic    qvalid;

    assign i_in.ready = room;
    assign take = i_in.valid && room;

    sisp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_take      (take),
        .i_byte      (i_in.data_byte),
        .i_eoi       (i_in.end_of_input),
        .o_push      (push)
    );

    sisp_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (qvalid && o_out.ready),
        .o_room  (room),
        .o_valid (qvalid),
        .o_res   (res)
    );

    assign o_out.valid        = qvalid;
    assign o_out.event_res    = res.event_res;
    assign o_out.chunk_kind   = res.chunk_kind;
    assign o_out.block_count  = res.block_count;
    assign o_out.word_value   = res.word_value;
    assign o_out.block_bytes  = res.block_bytes;
    assign o_out.payload_byte = res.payload_byte;
    assign o_out.error_code   = res.error_code;
    assign o_out.last_of_run  = res.last_of_run;

endmodule

// ----- verif/tb_sparse_image_stream_parser.sv -----
module tb_sparse_image_stream_parser;
    import sisp_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 400;
    localparam int TARGET_BYTES   = 1050;

    localparam int IMG_CLEAN        = 0;
    localparam int IMG_BAD_MAGIC    = 1;
    localparam int IMG_BAD_VERSION  = 2;
    localparam int IMG_BAD_HDR_LEN  = 3;
    localparam int IMG_BAD_CHK_LEN  = 4;
    localparam int IMG_BAD_BSIZE    = 5;
    localparam int IMG_MANY_CHUNKS  = 6;
    localparam int IMG_HUGE         = 7;
    localparam int IMG_BAD_TYPE     = 8;
    localparam int IMG_RAW_MISMATCH = 9;
    localparam int IMG_BLK_SHORT    = 10;
    localparam int IMG_BLK_EXCEED   = 11;
    localparam int IMG_FLIP         = 12;
    localparam int IMG_TRUNC        = 13;
    localparam int IMG_TRAIL        = 14;
    localparam int IMG_SHORT_CHUNK  = 15;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_input;
    } t_byte_item;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [62:0] i_cfg_wdata;

    sisp_in_if  in_if ();
    sisp_out_if out_if ();

    sparse_image_stream_parser i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if.sink),
        .o_out       (out_if.source)
    );

    // parser model state
    t_phase      ps_phase;
    logic [31:0] ps_cnt;
    logic [15:0] ps_hdr_len;
    logic [15:0] ps_chk_len;
    logic [31:0] ps_bsize;
    logic [31:0] ps_tblocks;
    logic [31:0] ps_tchunks;
    logic [20:0] ps_cdone;
    logic [63:0] ps_bseen;
    logic [15:0] ps_ctype;
    logic [31:0] ps_cblocks;
    logic [31:0] ps_pleft;
    logic [31:0] ps_word;
    logic        ps_failed;
    logic [62:0] size_limit;

    t_result    step_events[$];
    t_result    events_due[$];
    t_byte_item byte_q[$];
    logic [7:0] img[$];

    int n_pushed;
    int n_taken;
    int n_out;
    int errors;
    int stuck;
    int hold_left;
    bit hold_done;
    bit no_idle;
    t_byte_item cur_item;
    t_result    got;
    t_result    want;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic void clear_parser();
        ps_phase   = PH_HDR;
        ps_cnt     = '0;
        ps_hdr_len = '0;
        ps_chk_len = '0;
        ps_bsize   = '0;
        ps_tblocks = '0;
        ps_tchunks = '0;
        ps_cdone   = '0;
        ps_bseen   = '0;
        ps_ctype   = '0;
        ps_cblocks = '0;
        ps_pleft   = '0;
        ps_word    = '0;
        ps_failed  = 1'b0;
    endfunction

    function automatic void add_event(t_event ev, logic [1:0] kind, logic [31:0] blk,
                                      logic [31:0] w, logic [31:0] bs, logic [7:0] pb,
                                      t_err err);
        t_result r;
        if (step_events.size() >= 2) return;
        r.event_res    = ev;
        r.chunk_kind   = kind;
        r.block_count  = blk;
        r.word_value   = w;
        r.block_bytes  = bs;
        r.payload_byte = pb;
        r.error_code   = err;
        r.last_of_run  = 1'b0;
        step_events.push_back(r);
    endfunction

    function automatic void raise_error(t_err err);
        add_event(EV_ERROR, 2'd0, 32'd0, 32'd0, 32'd0, 8'd0, err);
        ps_failed = 1'b1;
    endfunction

    function automatic void close_image();
        if (ps_bseen != {32'd0, ps_tblocks}) raise_error(ERR_BLK_SHORT);
        else add_event(EV_DONE, 2'd0, 32'd0, 32'd0, 32'd0, 8'd0, ERR_NONE);
        ps_phase = PH_DONE;
    endfunction

    function automatic void next_chunk_header();
        ps_phase = PH_CHK;
        ps_cnt   = '0;
    endfunction

    function automatic void chunk_done();
        ps_cdone = ps_cdone + 21'd1;
        if ({11'd0, ps_cdone} == ps_tchunks) close_image();
        else next_chunk_header();
    endfunction

    function automatic logic [1:0] kind_of(logic [15:0] typ);
        logic [15:0] d;
        d = typ - SP_RAW;
        return d[1:0];
    endfunction

    function automatic void start_body();
        if (ps_ctype == SP_FILL || ps_ctype == SP_CRC) begin
            ps_phase = PH_WORD;
            ps_cnt   = '0;
            return;
        end
        add_event(EV_CHUNK, kind_of(ps_ctype), ps_cblocks, 32'd0, 32'd0, 8'd0, ERR_NONE);
        if (ps_ctype == SP_RAW && ps_pleft != 0) begin
            ps_phase = PH_RAW;
            ps_cnt   = '0;
        end else begin
            chunk_done();
        end
    endfunction

    function automatic void check_chunk_header(logic [31:0] total);
        logic [31:0] payload;
        if (total < {16'd0, ps_chk_len}) begin
            raise_error(ERR_CHUNK_SIZE);
            return;
        end
        payload  = total - {16'd0, ps_chk_len};
        ps_pleft = payload;
        if (ps_ctype == SP_RAW) begin
            if ({32'd0, payload} != {32'd0, ps_cblocks} * {32'd0, ps_bsize}) begin
                raise_error(ERR_RAW_SIZE);
                return;
            end
        end else if (ps_ctype == SP_FILL) begin
            if (payload != 32'd4) begin
                raise_error(ERR_PAYLOAD);
                return;
            end
        end else if (ps_ctype == SP_DONTCARE) begin
            if (payload != 32'd0) begin
                raise_error(ERR_DC_PAYLOAD);
                return;
            end
        end else if (ps_ctype == SP_CRC) begin
            if (payload != 32'd4) begin
                raise_error(ERR_PAYLOAD);
                return;
            end
            if (ps_cblocks != 32'd0) begin
                raise_error(ERR_CRC_BLOCKS);
                return;
            end
        end else begin
            raise_error(ERR_TYPE);
            return;
        end
        ps_bseen = ps_bseen + {32'd0, ps_cblocks};
        if (ps_bseen > {32'd0, ps_tblocks}) raise_error(ERR_BLK_EXCEED);
    endfunction

    function automatic void header_field(logic [31:0] c, logic [31:0] w);
        logic [63:0] expanded;
        case (c)
            32'd3: if (w != SP_MAGIC) raise_error(ERR_MAGIC);
            32'd5: if (w[31:16] != 16'd1) raise_error(ERR_VERSION);
            32'd9: ps_hdr_len = w[31:16];
            32'd11: begin
                ps_chk_len = w[31:16];
                if (ps_hdr_len < SP_HDR_LEN || ps_hdr_len > MAX_HEADER_LEN ||
                    ps_chk_len < SP_CHK_LEN || ps_chk_len > MAX_HEADER_LEN)
                    raise_error(ERR_HDR_SIZES);
            end
            32'd15: begin
                ps_bsize = w;
                if (w == 32'd0 || w[1:0] != 2'd0) raise_error(ERR_BLOCK_SIZE);
            end
            32'd19: ps_tblocks = w;
            32'd23: begin
                if (w > MAX_CHUNKS) begin
                    raise_error(ERR_CHUNK_COUNT);
                end else begin
                    ps_tchunks = w;
                    expanded = {32'd0, ps_tblocks} * {32'd0, ps_bsize};
                    if (expanded > {1'b0, size_limit}) raise_error(ERR_TOO_LARGE);
                end
            end
            32'd27: begin
                add_event(EV_HEADER, 2'd0, ps_tblocks, w, ps_bsize, 8'd0, ERR_NONE);
                if (ps_hdr_len <= SP_HDR_LEN) begin
                    if (ps_tchunks == 0) close_image();
                    else next_chunk_header();
                end else begin
                    ps_phase = PH_HDR_EXT;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void parse_byte(logic [7:0] b, logic eoi);
        logic [31:0] c;
        step_events.delete();
        if (!ps_failed && ps_phase != PH_DONE) begin
            c       = ps_cnt;
            ps_word = {b, ps_word[31:8]};
            ps_cnt  = c + 1;
            case (ps_phase)
                PH_HDR: header_field(c, ps_word);
                PH_HDR_EXT: begin
                    if (c + 1 >= {16'd0, ps_hdr_len}) begin
                        if (ps_tchunks == 0) close_image();
                        else next_chunk_header();
                    end
                end
                PH_CHK: begin
                    if (c == 1) ps_ctype = ps_word[31:16];
                    else if (c == 7) ps_cblocks = ps_word;
                    else if (c == 11) check_chunk_header(ps_word);
                    if (!ps_failed && c >= 11 && c + 1 >= {16'd0, ps_chk_len}) start_body();
                end
                PH_RAW: begin
                    add_event(EV_RAW, 2'd0, 32'd0, 32'd0, 32'd0, b, ERR_NONE);
                    ps_pleft = ps_pleft - 1;
                    if (ps_pleft == 0) chunk_done();
                end
                PH_WORD: begin
                    ps_pleft = ps_pleft - 1;
                    if (ps_pleft == 0) begin
                        add_event(EV_CHUNK, kind_of(ps_ctype), ps_cblocks, ps_word,
                                  32'd0, 8'd0, ERR_NONE);
                        chunk_done();
                    end
                end
                default: ;
            endcase
        end
        if (eoi) begin
            if (!ps_failed && ps_phase != PH_DONE) raise_error(ERR_TRUNCATED);
            clear_parser();
        end
        if (step_events.size() > 0) step_events[step_events.size() - 1].last_of_run = 1'b1;
        foreach (step_events[k]) events_due.push_back(step_events[k]);
    endfunction

    function automatic void put16(logic [15:0] v);
        img.push_back(v[7:0]);
        img.push_back(v[15:8]);
    endfunction

    function automatic void put32(logic [31:0] v);
        put16(v[15:0]);
        put16(v[31:16]);
    endfunction

    function automatic void poke32(int at, logic [31:0] v);
        for (int k = 0; k < 4; k++) img[at + k] = v[8 * k +: 8];
    endfunction

    function automatic void make_image(int mode, int nchunks);
        logic [7:0]  body[$];
        logic [15:0] hl;
        logic [15:0] cl;
        logic [15:0] typ;
        logic [31:0] bs;
        logic [31:0] tb;
        logic [31:0] blocks;
        logic [31:0] plen;
        int          cut;
        img.delete();
        hl = ($urandom_range(3) == 0) ? 16'(28 + $urandom_range(1, 6)) : 16'd28;
        cl = ($urandom_range(3) == 0) ? 16'(12 + $urandom_range(1, 4)) : 16'd12;
        bs = 32'(4 * $urandom_range(1, 4));
        tb = '0;
        for (int i = 0; i < nchunks; i++) begin
            typ = SP_RAW + 16'($urandom_range(3));
            if (mode == IMG_BAD_TYPE && i == nchunks - 1)
                typ = ($urandom_range(1)) ? 16'($urandom_range(16'hFFFF)) : 16'hCAC5;
            if (mode == IMG_RAW_MISMATCH && i == nchunks - 1) typ = SP_RAW;
            if (typ == SP_RAW) blocks = 32'($urandom_range(2));
            else if (typ == SP_CRC) blocks = 32'd0;
            else if (typ == SP_DONTCARE && $urandom_range(7) == 0) blocks = $urandom();
            else blocks = 32'($urandom_range(20));
            if (typ == SP_RAW) plen = blocks * bs;
            else if (typ == SP_FILL || typ == SP_CRC) plen = 32'd4;
            else plen = 32'd0;
            tb = tb + blocks;
            body.push_back(typ[7:0]);
            body.push_back(typ[15:8]);
            body.push_back(8'($urandom()));
            body.push_back(8'($urandom()));
            for (int k = 0; k < 4; k++) body.push_back(blocks[8 * k +: 8]);
            if (mode == IMG_RAW_MISMATCH && i == nchunks - 1)
                plen = plen + 32'($urandom_range(1, 3));
            if (mode == IMG_SHORT_CHUNK && i == nchunks - 1) begin
                for (int k = 0; k < 4; k++) body.push_back(8'(k == 0 ? cl - 1 : 0));
            end else begin
                for (int k = 0; k < 4; k++) body.push_back(8'((32'(cl) + plen) >> (8 * k)));
            end
            for (int k = 12; k < cl; k++) body.push_back(8'($urandom()));
            for (int k = 0; k < plen; k++) body.push_back(8'($urandom()));
        end
        if (mode == IMG_BLK_SHORT) tb = tb + 32'($urandom_range(1, 9));
        if (mode == IMG_BLK_EXCEED && tb != 0) tb = tb - 1;
        if (mode == IMG_HUGE) tb = 32'hFFFF_FFFF;
        put32(SP_MAGIC);
        put16(16'd1);
        put16(16'($urandom()));
        put16(hl);
        put16(cl);
        put32(bs);
        put32(tb);
        put32(32'(nchunks));
        put32($urandom());
        for (int k = 28; k < hl; k++) img.push_back(8'($urandom()));
        case (mode)
            IMG_BAD_MAGIC: img[$urandom_range(3)] ^= 8'(1 << $urandom_range(7));
            IMG_BAD_VERSION: img[4 + $urandom_range(1)] ^= 8'(1 << $urandom_range(7));
            IMG_BAD_HDR_LEN: begin
                img[8] = 8'($urandom());
                img[9] = ($urandom_range(1)) ? 8'd0 : 8'($urandom());
            end
            IMG_BAD_CHK_LEN: begin
                img[10] = 8'($urandom_range(11));
                img[11] = ($urandom_range(1)) ? 8'd0 : 8'($urandom_range(16, 255));
            end
            IMG_BAD_BSIZE:
                poke32(12, ($urandom_range(1)) ? 32'd0 : ($urandom() | 32'($urandom_range(1, 3))));
            IMG_MANY_CHUNKS: poke32(20, MAX_CHUNKS + 32'($urandom_range(1, 4)));
            default: ;
        endcase
        foreach (body[k]) img.push_back(body[k]);
        if (mode == IMG_FLIP) img[$urandom_range(img.size() - 1)] ^= 8'($urandom_range(1, 255));
        if (mode == IMG_TRUNC) begin
            cut = $urandom_range(1, img.size() - 1);
            while (img.size() > cut) void'(img.pop_back());
        end
        if (mode == IMG_TRAIL)
            for (int k = $urandom_range(1, 6); k > 0; k--) img.push_back(8'($urandom()));
        foreach (img[k]) byte_q.push_back({img[k], 1'(k == img.size() - 1)});
        n_pushed += img.size();
    endfunction

    task automatic wait_idle();
        do @(negedge i_clk); while (n_taken != n_pushed || events_due.size() != 0);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_limit(logic [62:0] v);
        wait_idle();
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        size_limit = v;
    endtask

    task automatic random_images(int bytes);
        int stop_at;
        int r;
        stop_at = n_pushed + bytes;
        while (n_pushed < stop_at) begin
            r = $urandom_range(99);
            if (r < 55) make_image(IMG_CLEAN, $urandom_range(0, 4));
            else if (r < 65) make_image(IMG_TRAIL, $urandom_range(0, 3));
            else if (r < 78) make_image(IMG_FLIP, $urandom_range(1, 3));
            else if (r < 86) make_image(IMG_TRUNC, $urandom_range(0, 3));
            else make_image($urandom_range(IMG_BAD_MAGIC, IMG_BLK_EXCEED), $urandom_range(1, 3));
        end
    endtask

    // input side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid        <= 1'b0;
            in_if.data_byte    <= 8'd0;
            in_if.end_of_input <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                parse_byte(in_if.data_byte, in_if.end_of_input);
                n_taken <= n_taken + 1;
            end
            if (!in_if.valid || in_if.ready) begin
                if (byte_q.size() > 0 && (no_idle || $urandom_range(99) >= 31)) begin
                    cur_item = byte_q.pop_front();
                    in_if.valid        <= 1'b1;
                    in_if.data_byte    <= cur_item.data_byte;
                    in_if.end_of_input <= cur_item.end_of_input;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // output side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                n_out++;
                got.event_res    = t_event'(out_if.event_res);
                got.chunk_kind   = out_if.chunk_kind;
                got.block_count  = out_if.block_count;
                got.word_value   = out_if.word_value;
                got.block_bytes  = out_if.block_bytes;
                got.payload_byte = out_if.payload_byte;
                got.error_code   = t_err'(out_if.error_code);
                got.last_of_run  = out_if.last_of_run;
                if (events_due.size() == 0) begin
                    $display("%0t: unexpected transfer, expected none actual %p", $time, got);
                    errors++;
                end else begin
                    want = events_due.pop_front();
                    check_field("event_res", want.event_res, got.event_res);
                    check_field("chunk_kind", want.chunk_kind, got.chunk_kind);
                    check_field("block_count", want.block_count, got.block_count);
                    check_field("word_value", want.word_value, got.word_value);
                    check_field("block_bytes", want.block_bytes, got.block_bytes);
                    check_field("payload_byte", want.payload_byte, got.payload_byte);
                    check_field("error_code", want.error_code, got.error_code);
                    check_field("last_of_run", want.last_of_run, got.last_of_run);
                end
            end
            if (hold_left > 0) begin
                hold_left    <= hold_left - 1;
                out_if.ready <= 1'b0;
            end else if (!hold_done && n_out >= 40) begin
                hold_done    <= 1'b1;
                hold_left    <= HOLD_CYCLES;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= no_idle || $urandom_range(99) >= 31;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((n_taken != n_pushed || events_due.size() != 0) &&
            !(in_if.valid && in_if.ready) && !(out_if.valid && out_if.ready)) begin
            stuck <= stuck + 1;
            if (stuck >= WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end else begin
            stuck <= 0;
        end
    end

    initial begin
        in_if.valid        = 1'b0;
        in_if.data_byte    = 8'd0;
        in_if.end_of_input = 1'b0;
        out_if.ready       = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        i_rst_n     = 1'b0;
        n_pushed  = 0;
        n_taken   = 0;
        n_out     = 0;
        errors    = 0;
        stuck     = 0;
        hold_left = 0;
        hold_done = 1'b0;
        no_idle   = 1'b0;
        size_limit = SP_DEFAULT_MAX;
        clear_parser();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed
        make_image(IMG_CLEAN, 0);
        make_image(IMG_CLEAN, 3);
        make_image(IMG_BAD_MAGIC, 1);
        make_image(IMG_BAD_VERSION, 1);
        make_image(IMG_BAD_HDR_LEN, 1);
        make_image(IMG_BAD_CHK_LEN, 1);
        make_image(IMG_BAD_BSIZE, 1);
        make_image(IMG_MANY_CHUNKS, 1);
        make_image(IMG_HUGE, 1);
        make_image(IMG_BAD_TYPE, 2);
        make_image(IMG_RAW_MISMATCH, 1);
        make_image(IMG_SHORT_CHUNK, 1);
        make_image(IMG_BLK_SHORT, 2);
        make_image(IMG_BLK_EXCEED, 2);
        make_image(IMG_TRAIL, 1);
        make_image(IMG_TRUNC, 2);

        write_limit('0);
        random_images(40);
        write_limit({63{1'b1}});
        make_image(IMG_HUGE, 2);
        random_images(40);
        write_limit(63'($urandom_range(0, 4096)));
        random_images(40);
        write_limit(SP_DEFAULT_MAX);
        no_idle = 1'b1;
        random_images(100);
        wait_idle();
        no_idle = 1'b0;
        random_images(TARGET_BYTES - n_pushed);

        wait_idle();
        repeat (20) @(negedge i_clk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/sisp_pkg.sv
rtl/sisp_if.sv
rtl/sisp_core.sv
rtl/sisp_outq.sv
rtl/sparse_image_stream_parser.sv
verif/tb_sparse_image_stream_parser.sv
